// ===== rtl/ttfs_pkg.sv =====
`timescale 1ns / 1ps

package ttfs_pkg;

  localparam int unsigned DEPTH  = 4096;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CW     = $clog2(DEPTH + 1);
  localparam int unsigned HW     = CW + 1;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PROBE,
    S_FINAL,
    S_EMIT
  } state_e;

endpackage

// ===== rtl/ttfs_ram.sv =====
`timescale 1ns / 1ps

module ttfs_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/time_table_floor_search_core.sv =====
`timescale 1ns / 1ps

// Ascending time table with a floor-style binary search. Clear and append
// words are answered in the cycle after they are taken; an append to a full
// table is dropped and answered with status 1. A query runs a binary search
// over the stored rows: each probe is one read of the single read port of
// the table RAM, then one 64-bit signed compare. The search ends early on an
// exact match or a table of at most one row. The block takes no new word
// while a query runs. The result is held in an output register, and the
// next word is taken no earlier than the cycle in which the previous result
// is taken.

module time_table_floor_search_core
  import ttfs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic signed [TIME_W-1:0] time_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [ROW_W-1:0]         row_index_o,
  output logic                     status_o
);

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  logic [ROW_W-1:0]         row_q, row_d;
  logic                     status_q, status_d;
  logic signed [TIME_W-1:0] time_q, time_d;
  logic [AW-1:0]            low_q, low_d;
  logic signed [HW-1:0]     high_q, high_d;
  logic [AW-1:0]            mid_q, mid_d;
  logic [AW-1:0]            res_q, res_d;

  logic                     ram_we;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [TIME_W-1:0]        ram_rdata;
  logic signed [TIME_W-1:0] probe_s;
  logic [HW-1:0]            sum_w;
  logic [AW-1:0]            mid_w;
  logic signed [HW-1:0]     low_s;
  logic                     slot_free;

  ttfs_ram #(
    .WIDTH(TIME_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(count_q)),
    .wdata_i(time_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign probe_s   = $signed(ram_rdata);
  assign low_s     = $signed(HW'(low_q));
  assign sum_w     = HW'(low_q) + $unsigned(high_q);
  assign mid_w     = AW'(sum_w >> 1);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    row_d       = row_q;
    status_d    = status_q;
    time_d      = time_q;
    low_d       = low_q;
    high_d      = high_q;
    mid_d       = mid_q;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = mid_w;
    in_ready_o  = (state_q == S_IDLE) && slot_free;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          case (mode_e'(mode_i))
            MODE_CLEAR: begin
              count_d     = '0;
              out_valid_d = 1'b1;
              row_d       = '0;
              status_d    = STATUS_OK;
            end
            MODE_APPEND: begin
              out_valid_d = 1'b1;
              row_d       = '0;
              if (count_q < CW'(DEPTH)) begin
                ram_we   = 1'b1;
                count_d  = count_q + 1'b1;
                status_d = STATUS_OK;
              end else begin
                status_d = STATUS_FULL;
              end
            end
            MODE_QUERY: begin
              time_d  = time_value_i;
              low_d   = '0;
              high_d  = HW'($signed(HW'(count_q)) - 1);
              state_d = S_CHECK;
            end
            default: begin
              out_valid_d = 1'b1;
              row_d       = '0;
              status_d    = STATUS_OK;
            end
          endcase
        end
      end
      S_CHECK: begin
        if (high_q <= 0) begin
          res_d   = '0;
          state_d = S_EMIT;
        end else if (low_s >= high_q) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(high_q);
          state_d   = S_FINAL;
        end else begin
          ram_re  = 1'b1;
          mid_d   = mid_w;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (time_q == probe_s) begin
          res_d   = mid_q;
          state_d = S_EMIT;
        end else begin
          if (time_q < probe_s) begin
            high_d = HW'($signed(HW'(mid_q)) - 1);
          end else begin
            low_d = mid_q + 1'b1;
          end
          state_d = S_CHECK;
        end
      end
      S_FINAL: begin
        if (probe_s > time_q) begin
          res_d = AW'(high_q - 1);
        end else begin
          res_d = AW'(high_q);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          row_d       = ROW_W'(res_q);
          status_d    = STATUS_OK;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    status_q <= status_d;
    time_q   <= time_d;
    low_q    <= low_d;
    high_q   <= high_d;
    mid_q    <= mid_d;
    res_q    <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_q;
  assign status_o    = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("row count above depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("word taken during a search");

  a_probe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE || state_q == S_FINAL) |-> ($past(state_q) == S_CHECK))
    else $error("compare without a read");

  a_append_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == MODE_APPEND && count_q < CW'(DEPTH))
    |=> (count_q == $past(count_q) + 1'b1))
    else $error("append did not advance the row count");

  a_full_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (row_index_o == '0))
    else $error("dropped append with a nonzero row");

endmodule
